### sv/pss_pkg.sv
// Shared types and constants for the PWM startup stretch unit.
`default_nettype none

package pss_pkg;

  // Beat widths on the stream and configuration ports
  localparam int IN_DATA_BITS  = 24;
  localparam int OUT_DATA_BITS = 24;
  localparam int CMD_BITS      = 2;
  localparam int CHAN_BITS     = 2;
  localparam int VALUE_BITS    = 16;
  localparam int PINS_BITS     = 3;
  localparam int TICK_OUT_BITS = 16;
  localparam int CFG_IDX_BITS  = 8;
  localparam int CFG_DATA_BITS = 16;
  localparam int USE_BITS      = 2;

  // Reset values
  localparam logic [31:0]           PERIOD_RESET  = 32'd4095;
  localparam logic [USE_BITS-1:0]   USE_RESET     = 2'd3;
  localparam logic [VALUE_BITS-1:0] STARTUP_RESET = 16'd128;

  // Configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_CHANNELS_IN_USE = 8'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_STARTUP_TICKS   = 8'd1;

  // Command codes
  typedef enum logic [CMD_BITS-1:0] {
    CMD_TICK       = 2'd0,
    CMD_SET_DUTY   = 2'd1,
    CMD_SET_PERIOD = 2'd2,
    CMD_SET_ENABLE = 2'd3
  } cmd_t;

  // One registered input item
  typedef struct packed {
    cmd_t                  command;
    logic [CHAN_BITS-1:0]  channel;
    logic [VALUE_BITS-1:0] value;
  } item_t;

  // One result item
  typedef struct packed {
    logic [PINS_BITS-1:0]     pin_levels;
    logic [PINS_BITS-1:0]     running_mask;
    logic                     period_end;
    logic [TICK_OUT_BITS-1:0] tick_count;
  } result_t;

  // Configuration register contents
  typedef struct packed {
    logic [USE_BITS-1:0]   channels_in_use;
    logic [VALUE_BITS-1:0] startup_ticks;
  } cfg_t;

endpackage

`default_nettype wire

### sv/pss_cfg_regs.sv
// Configuration register file: channels in use and startup tick count.
`default_nettype none

module pss_cfg_regs
  import pss_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_data,
  output cfg_t                          cfg
);

  cfg_t regs;

  // Writes are always accepted; cfg_ready is tied high
  assign cfg_ready = 1'b1;
  assign cfg       = regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.channels_in_use <= USE_RESET;
      regs.startup_ticks   <= STARTUP_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_CHANNELS_IN_USE: regs.channels_in_use <= cfg_data[USE_BITS-1:0];
        REG_STARTUP_TICKS:   regs.startup_ticks   <= cfg_data[VALUE_BITS-1:0];
        default: ;  // unknown index: write is dropped
      endcase
    end
  end

endmodule

`default_nettype wire

### sv/pss_core.sv
// PWM state: counter, double-buffered duty/period, per-channel level and mode.
`default_nettype none

module pss_core
  import pss_pkg::*;
#(
  parameter int CHANNELS   = 3,
  parameter int COUNT_BITS = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic fire,     // item in the input register is processed now
  input  item_t     item,
  input  cfg_t      cfg,
  output result_t   result    // result of the item, from the updated state
);

  // Wide enough for both the built channel count and the channels-in-use register
  localparam int CH_BITS = ($clog2(CHANNELS + 1) > USE_BITS) ? $clog2(CHANNELS + 1) : USE_BITS;
  // Width wide enough for both a count value and the 16-bit startup ticks
  localparam int CMP_BITS = (COUNT_BITS > VALUE_BITS) ? COUNT_BITS : VALUE_BITS;

  logic [COUNT_BITS-1:0] tick_counter, tick_counter_next;
  logic [COUNT_BITS-1:0] period_active, period_active_next;
  logic [COUNT_BITS-1:0] period_pending, period_pending_next;
  logic [COUNT_BITS-1:0] duty_pending [CHANNELS];
  logic [COUNT_BITS-1:0] duty_pending_next [CHANNELS];
  logic [COUNT_BITS-1:0] compare_active [CHANNELS];
  logic [COUNT_BITS-1:0] compare_active_next [CHANNELS];
  logic [CHANNELS-1:0]   chan_running, chan_running_next;
  logic [CHANNELS-1:0]   chan_level, chan_level_next;
  logic                  block_enabled, block_enabled_next;
  logic                  period_end_next;

  logic [COUNT_BITS-1:0] val_m;
  logic [COUNT_BITS-1:0] startup_m;
  logic [CMP_BITS-1:0]   startup_w;
  logic [COUNT_BITS:0]   count_inc;
  logic [CH_BITS-1:0]    served;
  logic [CHANNELS+2:0]   level_pad, running_pad;

  assign val_m     = COUNT_BITS'(item.value);
  assign startup_m = COUNT_BITS'(cfg.startup_ticks);
  assign startup_w = CMP_BITS'(cfg.startup_ticks);
  assign count_inc = {1'b0, tick_counter} + 1'b1;

  // Channels served at a boundary, clipped to what is built
  always_comb begin
    if (CH_BITS'(cfg.channels_in_use) > CH_BITS'(CHANNELS)) begin
      served = CH_BITS'(CHANNELS);
    end else begin
      served = CH_BITS'(cfg.channels_in_use);
    end
  end

  // Next-state logic for one item
  always_comb begin
    tick_counter_next   = tick_counter;
    period_active_next  = period_active;
    period_pending_next = period_pending;
    chan_running_next   = chan_running;
    chan_level_next     = chan_level;
    block_enabled_next  = block_enabled;
    period_end_next     = 1'b0;
    for (int i = 0; i < CHANNELS; i++) begin
      duty_pending_next[i]   = duty_pending[i];
      compare_active_next[i] = compare_active[i];
    end

    case (item.command)
      CMD_TICK: begin
        if (block_enabled) begin
          if (count_inc >= {1'b0, period_active}) begin
            // Period boundary: reload pending values
            period_end_next    = 1'b1;
            tick_counter_next  = '0;
            period_active_next = period_pending;
            for (int i = 0; i < CHANNELS; i++) begin
              if (i >= int'(served) || duty_pending[i] == '0) begin
                chan_level_next[i]   = 1'b0;
                chan_running_next[i] = 1'b0;
              end else if (duty_pending[i] >= period_pending) begin
                chan_level_next[i]   = 1'b1;
                chan_running_next[i] = 1'b0;
              end else begin
                compare_active_next[i] = duty_pending[i];
                // First toggling period is stretched to the startup time
                if (!chan_running[i]) begin
                  chan_running_next[i] = 1'b1;
                  if (CMP_BITS'(duty_pending[i]) < startup_w) begin
                    compare_active_next[i] = startup_m;
                  end
                end
                chan_level_next[i] = 1'b1;
              end
            end
          end else begin
            tick_counter_next = count_inc[COUNT_BITS-1:0];
            for (int i = 0; i < CHANNELS; i++) begin
              if (chan_running[i] && compare_active[i] == count_inc[COUNT_BITS-1:0]) begin
                chan_level_next[i] = 1'b0;
              end
            end
          end
        end
      end
      CMD_SET_DUTY: begin
        // Writes to channels that are not built fall through the loop
        for (int i = 0; i < CHANNELS; i++) begin
          if (int'(item.channel) == i) begin
            duty_pending_next[i] = val_m;
          end
        end
      end
      CMD_SET_PERIOD: begin
        period_pending_next = val_m;
      end
      CMD_SET_ENABLE: begin
        if (item.value[0]) begin
          block_enabled_next = 1'b1;
        end else begin
          block_enabled_next = 1'b0;
          chan_level_next    = '0;
          chan_running_next  = '0;
        end
      end
      default: ;
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_counter   <= '0;
      period_active  <= COUNT_BITS'(PERIOD_RESET);
      period_pending <= COUNT_BITS'(PERIOD_RESET);
      chan_running   <= '0;
      chan_level     <= '0;
      block_enabled  <= 1'b1;
      for (int i = 0; i < CHANNELS; i++) begin
        duty_pending[i]   <= '0;
        compare_active[i] <= '0;
      end
    end else if (fire) begin
      tick_counter   <= tick_counter_next;
      period_active  <= period_active_next;
      period_pending <= period_pending_next;
      chan_running   <= chan_running_next;
      chan_level     <= chan_level_next;
      block_enabled  <= block_enabled_next;
      for (int i = 0; i < CHANNELS; i++) begin
        duty_pending[i]   <= duty_pending_next[i];
        compare_active[i] <= compare_active_next[i];
      end
    end
  end

  // Result shows the first three channels only
  assign level_pad   = {3'b000, chan_level_next};
  assign running_pad = {3'b000, chan_running_next};

  assign result.pin_levels   = level_pad[PINS_BITS-1:0];
  assign result.running_mask = running_pad[PINS_BITS-1:0];
  assign result.period_end   = period_end_next;
  assign result.tick_count   = TICK_OUT_BITS'(tick_counter_next);

endmodule

`default_nettype wire

### sv/pwm_startup_stretch_unit.sv
// Top level: input register, PWM core and result register.
//
//  Channel | Dir | Handshake            | Contents
//  s_*     | in  | s_tvalid / s_tready  | tuser command, tdata channel + value
//  m_*     | out | m_tvalid / m_tready  | tdata pins, running, period end, count
//  cfg_*   | in  | cfg_valid / cfg_ready| register index + write data
//
// One item per cycle while m_tready stays high; a result beat passes through the
// input register, then the result register, before it is presented.
// The PWM state update and result computation happen in the same cycle, from
// the input register.
// Synchronous reset clears the pipeline valids, the PWM state and the
// configuration registers; cfg_ready is always high.
// A stalled result register holds its beat while the input register can
// still take one more beat.
`default_nettype none

module pwm_startup_stretch_unit
  import pss_pkg::*;
#(
  parameter int CHANNELS   = 3,
  parameter int COUNT_BITS = 16
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  // Input stream
  input  wire logic                     s_tvalid,
  output logic                          s_tready,
  input  wire logic [IN_DATA_BITS-1:0]  s_tdata,   // [1:0] channel, [17:2] value
  input  wire logic [CMD_BITS-1:0]      s_tuser,   // [1:0] command
  // Result stream
  output logic                          m_tvalid,
  input  wire logic                     m_tready,
  // [2:0] pin_levels, [5:3] running_mask, [6] period_end, [22:7] tick_count
  output logic [OUT_DATA_BITS-1:0]      m_tdata,
  // Configuration writes
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_data
);

  cfg_t    cfg;
  item_t   in_item;
  logic    in_valid;
  result_t result;
  result_t out_result;
  logic    out_valid;
  logic    advance;
  logic    fire;

  pss_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Pipeline moves when the result register is free or being drained
  assign advance  = !out_valid || m_tready;
  assign fire     = in_valid && advance;
  assign s_tready = !in_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tvalid && s_tready) begin
      in_item.command <= cmd_t'(s_tuser);
      in_item.channel <= s_tdata[CHAN_BITS-1:0];
      in_item.value   <= s_tdata[CHAN_BITS +: VALUE_BITS];
    end
  end

  pss_core #(
    .CHANNELS   (CHANNELS),
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .item   (in_item),
    .cfg    (cfg),
    .result (result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
    if (fire) begin
      out_result <= result;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = OUT_DATA_BITS'({out_result.tick_count, out_result.period_end,
                                    out_result.running_mask, out_result.pin_levels});

endmodule

`default_nettype wire

### sv/pss_checker.sv
// Port-level checks for the PWM startup stretch unit, bound to the top level.
`default_nettype none

module pss_checker
  import pss_pkg::*;
(
  input wire logic                     clk,
  input wire logic                     rst,
  input wire logic                     m_tvalid,
  input wire logic                     m_tready,
  input wire logic [OUT_DATA_BITS-1:0] m_tdata
);

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result beat changed while stalled");

  // A period end always restarts the counter at zero
  a_end_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[6] |-> m_tdata[22:7] == 16'd0)
    else $error("period end with nonzero count");

  // At a boundary every toggling channel starts high
  a_end_high: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[6] |-> (m_tdata[5:3] & ~m_tdata[2:0]) == 3'b000)
    else $error("running channel low at period start");

  // Pad bit stays clear
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[23] == 1'b0)
    else $error("result pad bit set");

endmodule

bind pwm_startup_stretch_unit pss_checker u_pss_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
